### rtl/rdc_pkg.sv
// ----------------------------------------------------------------------------
// rdc_pkg
// Shared types and constants for the rotary dial controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rdc_pkg;

  // dial actions
  typedef enum logic [1:0] {
    ACT_PRESS   = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_CW      = 2'd2,
    ACT_CCW     = 2'd3
  } action_t;

  // event kinds
  typedef enum logic [2:0] {
    EV_TOGGLE = 3'd0,
    EV_INC    = 3'd1,
    EV_DEC    = 3'd2,
    EV_INC2   = 3'd3,
    EV_DEC2   = 3'd4
  } event_kind_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_ACCEL_MULT = 3'd0,
    REG_DUAL_MODE  = 3'd1,
    REG_RADIO_MODE = 3'd2,
    REG_BOUND_MASK = 3'd3,
    REG_DC_WINDOW  = 3'd4
  } cfg_idx_t;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  // reset values of the configuration registers
  localparam logic [7:0]  AccelMultReset = 8'd3;
  localparam logic [15:0] DcWindowReset  = 16'd400;

  // acceleration curve: full speed at or below FastMs, none at or above SlowMs
  localparam logic [31:0] AccelFastMs = 32'd15;
  localparam logic [31:0] AccelSlowMs = 32'd120;
  localparam logic [6:0]  AccelSlowN  = 7'd120;

  // floor(n * 2^16 / 105) == (n * RecipM) >> RecipShift for n < 105
  localparam logic [23:0] RecipM     = 24'd10226113;
  localparam int          RecipShift = 14;

  // shared multiplier: A operand 40 bits, B operand 16 bits
  localparam int MulAW = 40;
  localparam int MulBW = 16;
  localparam int MulPW = MulAW + MulBW;

  typedef enum logic [1:0] {
    MUL_RECIP = 2'd0,   // t = (n * RecipM) >> RecipShift
    MUL_M1    = 2'd1,   // p = (m - 1) * t
    MUL_P     = 2'd2    // p = p * t
  } mul_sel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RECIP,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic     load;     // decode accepted request, update dial state
    logic     mul_en;   // run one multiplier pass
    mul_sel_t mul_sel;
    logic     emit;     // move pending result into output register
  } cmd_t;

  typedef struct packed {
    logic need_mul;     // request needs the cubic acceleration passes
  } status_t;

endpackage

`default_nettype wire

### rtl/rdc_ctrl.sv
// ----------------------------------------------------------------------------
// rdc_ctrl
// Sequencer: accepts a request, runs the multiplier passes when needed, emits the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rdc_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  wire logic            out_stall,
  input  wire rdc_pkg::status_t status,
  output rdc_pkg::cmd_t        cmd
);

  rdc_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rdc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd.load    = 1'b0;
    cmd.mul_en  = 1'b0;
    cmd.mul_sel = rdc_pkg::MUL_RECIP;
    cmd.emit    = 1'b0;
    in_stall    = (state != rdc_pkg::ST_IDLE);
    case (state)
      rdc_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = status.need_mul ? rdc_pkg::ST_RECIP : rdc_pkg::ST_EMIT;
        end
      end
      rdc_pkg::ST_RECIP: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = rdc_pkg::MUL_RECIP;
        state_next  = rdc_pkg::ST_MUL1;
      end
      rdc_pkg::ST_MUL1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = rdc_pkg::MUL_M1;
        state_next  = rdc_pkg::ST_MUL2;
      end
      rdc_pkg::ST_MUL2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = rdc_pkg::MUL_P;
        state_next  = rdc_pkg::ST_MUL3;
      end
      rdc_pkg::ST_MUL3: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = rdc_pkg::MUL_P;
        state_next  = rdc_pkg::ST_EMIT;
      end
      rdc_pkg::ST_EMIT: begin
        if (!out_valid || !out_stall) begin
          cmd.emit   = 1'b1;
          state_next = rdc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rdc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

### rtl/rdc_datapath.sv
// ----------------------------------------------------------------------------
// rdc_datapath
// Configuration, dial state, event decode, shared multiplier, output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rdc_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // request fields
  input  wire logic [1:0]                    action,
  input  wire logic [31:0]                   now_ms,
  input  wire logic                          link_up,
  // configuration writes
  input  wire logic                          cfg_we,
  input  wire logic [rdc_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [rdc_pkg::CfgDataW-1:0]  cfg_data,
  // control
  input  wire rdc_pkg::cmd_t                 cmd,
  output rdc_pkg::status_t                   status,
  // result fields
  output logic                               send_event,
  output logic [2:0]                         event_kind,
  output logic [7:0]                         repeat_count,
  output logic                               reconnect_request,
  output logic                               selected_dial,
  output logic                               selected_radio_part,
  output logic                               double_click
);

  // configuration
  logic [7:0]  accel_multiplier;
  logic        dual_mode;
  logic        radio_mode;
  logic [4:0]  bound_mask;
  logic [15:0] double_click_window;

  // dial state
  logic        dial_select, dial_select_next;
  logic        radio_part, radio_part_next;
  logic        click_pending, click_pending_next;
  logic [31:0] last_click_time, last_click_time_next;
  logic        rotation_seen, rotation_seen_next;
  logic [31:0] last_rotation_time, last_rotation_time_next;

  // pending result
  logic        res_send, res_send_next;
  logic [2:0]  res_kind, res_kind_next;
  logic [7:0]  res_rep, res_rep_next;
  logic        res_recon, res_recon_next;
  logic        res_dbl, res_dbl_next;
  logic        use_mul;
  logic [6:0]  n_r, n_next;

  // multiplier
  logic [rdc_pkg::MulAW-1:0] mul_a;
  logic [rdc_pkg::MulBW-1:0] mul_b;
  logic [rdc_pkg::MulPW-1:0] mul_full;
  logic [rdc_pkg::MulPW-1:0] prod;
  logic [15:0]               t_r;
  logic [rdc_pkg::MulPW:0]   rounded;
  logic [7:0]                rep_final;

  logic [31:0] click_gap;
  logic [31:0] rot_gap;
  logic        second;
  logic [2:0]  rot_kind;
  logic        need_mul;

  assign click_gap = now_ms - last_click_time;
  assign rot_gap   = now_ms - last_rotation_time;
  assign second    = (dual_mode && dial_select) || (radio_mode && radio_part);

  always_comb begin
    if (rdc_pkg::action_t'(action) == rdc_pkg::ACT_CW) begin
      rot_kind = second ? rdc_pkg::EV_INC2 : rdc_pkg::EV_INC;
    end else begin
      rot_kind = second ? rdc_pkg::EV_DEC2 : rdc_pkg::EV_DEC;
    end
  end

  // request decode
  always_comb begin
    dial_select_next        = dial_select;
    radio_part_next         = radio_part;
    click_pending_next      = click_pending;
    last_click_time_next    = last_click_time;
    rotation_seen_next      = rotation_seen;
    last_rotation_time_next = last_rotation_time;
    res_send_next           = 1'b0;
    res_kind_next           = rdc_pkg::EV_TOGGLE;
    res_rep_next            = 8'd0;
    res_recon_next          = 1'b0;
    res_dbl_next            = 1'b0;
    need_mul                = 1'b0;
    n_next                  = 7'(rdc_pkg::AccelSlowN - rot_gap[6:0]);
    case (rdc_pkg::action_t'(action))
      rdc_pkg::ACT_PRESS: begin
        if (!link_up) begin
          res_recon_next = 1'b1;
        end else if (!radio_mode && bound_mask[rdc_pkg::EV_TOGGLE]) begin
          res_send_next = 1'b1;
          res_rep_next  = 8'd1;
        end
      end
      rdc_pkg::ACT_RELEASE: begin
        if (radio_mode) begin
          if (click_pending && (click_gap <= 32'(double_click_window))) begin
            click_pending_next = 1'b0;
            res_dbl_next       = 1'b1;
            if (bound_mask[rdc_pkg::EV_TOGGLE]) begin
              res_send_next = 1'b1;
              res_rep_next  = 8'd1;
            end
          end else begin
            radio_part_next      = ~radio_part;
            click_pending_next   = 1'b1;
            last_click_time_next = now_ms;
          end
        end else if (dual_mode) begin
          dial_select_next = ~dial_select;
        end
      end
      default: begin
        if (bound_mask[rot_kind]) begin
          res_send_next = 1'b1;
          res_kind_next = rot_kind;
          res_rep_next  = 8'd1;
          if (accel_multiplier != 8'd0) begin
            last_rotation_time_next = now_ms;
            if (!rotation_seen) begin
              rotation_seen_next = 1'b1;
            end else if (rot_gap <= rdc_pkg::AccelFastMs) begin
              // full speed: 1 + (m - 1) == m
              res_rep_next = accel_multiplier;
            end else if (rot_gap < rdc_pkg::AccelSlowMs) begin
              need_mul = 1'b1;
            end
          end
        end
      end
    endcase
  end

  assign status.need_mul = need_mul;

  always_ff @(posedge clk) begin
    if (rst) begin
      accel_multiplier    <= rdc_pkg::AccelMultReset;
      dual_mode           <= 1'b0;
      radio_mode          <= 1'b0;
      bound_mask          <= 5'd0;
      double_click_window <= rdc_pkg::DcWindowReset;
      dial_select         <= 1'b0;
      radio_part          <= 1'b0;
      click_pending       <= 1'b0;
      last_click_time     <= 32'd0;
      rotation_seen       <= 1'b0;
      last_rotation_time  <= 32'd0;
    end else begin
      if (cfg_we) begin
        case (rdc_pkg::cfg_idx_t'(cfg_index))
          rdc_pkg::REG_ACCEL_MULT: accel_multiplier    <= cfg_data[7:0];
          rdc_pkg::REG_DUAL_MODE:  dual_mode           <= cfg_data[0];
          rdc_pkg::REG_RADIO_MODE: radio_mode          <= cfg_data[0];
          rdc_pkg::REG_BOUND_MASK: bound_mask          <= cfg_data[4:0];
          rdc_pkg::REG_DC_WINDOW:  double_click_window <= cfg_data;
          default: begin
          end
        endcase
      end
      if (cmd.load) begin
        dial_select        <= dial_select_next;
        radio_part         <= radio_part_next;
        click_pending      <= click_pending_next;
        last_click_time    <= last_click_time_next;
        rotation_seen      <= rotation_seen_next;
        last_rotation_time <= last_rotation_time_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_send  <= res_send_next;
      res_kind  <= res_kind_next;
      res_rep   <= res_rep_next;
      res_recon <= res_recon_next;
      res_dbl   <= res_dbl_next;
      use_mul   <= need_mul;
      n_r       <= n_next;
    end
  end

  // shared multiplier, one pass a cycle
  always_comb begin
    case (cmd.mul_sel)
      rdc_pkg::MUL_RECIP: begin
        mul_a = rdc_pkg::MulAW'(rdc_pkg::RecipM);
        mul_b = rdc_pkg::MulBW'(n_r);
      end
      rdc_pkg::MUL_M1: begin
        mul_a = rdc_pkg::MulAW'(accel_multiplier - 8'd1);
        mul_b = t_r;
      end
      rdc_pkg::MUL_P: begin
        mul_a = prod[rdc_pkg::MulAW-1:0];
        mul_b = t_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_full = rdc_pkg::MulPW'(mul_a) * rdc_pkg::MulPW'(mul_b);

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      if (cmd.mul_sel == rdc_pkg::MUL_RECIP) begin
        t_r <= mul_full[rdc_pkg::RecipShift +: 16];
      end else begin
        prod <= mul_full;
      end
    end
  end

  // 1 + round_half_up((m - 1) * t^3 / 2^48)
  assign rounded   = (rdc_pkg::MulPW + 1)'(prod) + ((rdc_pkg::MulPW + 1)'(1) << 47);
  assign rep_final = rounded[55:48] + 8'd1;

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      send_event          <= res_send;
      event_kind          <= res_kind;
      repeat_count        <= use_mul ? rep_final : res_rep;
      reconnect_request   <= res_recon;
      selected_dial       <= dial_select;
      selected_radio_part <= radio_part;
      double_click        <= res_dbl;
    end
  end

endmodule

`default_nettype wire

### rtl/rotary_dial_controller_top.sv
// ----------------------------------------------------------------------------
// rotary_dial_controller_top
// Dial event controller: toggle/inc/dec routing, double click, acceleration.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake              Payload
//  -------   ---------------------  ------------------------------------------
//  in        in_valid / in_stall    action, now_ms, link_up
//  out       out_valid / out_stall  send_event, event_kind, repeat_count,
//                                   reconnect_request, selected_dial,
//                                   selected_radio_part, double_click
//  cfg       cfg_valid / cfg_ready  cfg_index, cfg_data (always ready)
//
//  Press, release and unaccelerated steps go from accept straight to emit.
//  Accelerated steps first run the cube of the speed term as four
//  passes through one shared 40x16 multiplier (reciprocal, then three products).
//  in_stall is high from the cycle after accept until the result moves into
//  the output register; a new request is taken while that result waits.
//  rst (synchronous) restores register defaults and clears all dial state.
//
`timescale 1ns / 1ps
`default_nettype none

module rotary_dial_controller_top (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // request channel
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [1:0]                   action,
  input  wire logic [31:0]                  now_ms,
  input  wire logic                         link_up,
  // result channel
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              send_event,
  output logic [2:0]                        event_kind,
  output logic [7:0]                        repeat_count,
  output logic                              reconnect_request,
  output logic                              selected_dial,
  output logic                              selected_radio_part,
  output logic                              double_click,
  // configuration channel
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [rdc_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [rdc_pkg::CfgDataW-1:0] cfg_data
);

  rdc_pkg::cmd_t    cmd;
  rdc_pkg::status_t status;

  // register writes take effect directly, so the port never pushes back
  assign cfg_ready = 1'b1;

  rdc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  rdc_datapath u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .action              (action),
    .now_ms              (now_ms),
    .link_up             (link_up),
    .cfg_we              (cfg_valid && cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .cmd                 (cmd),
    .status              (status),
    .send_event          (send_event),
    .event_kind          (event_kind),
    .repeat_count        (repeat_count),
    .reconnect_request   (reconnect_request),
    .selected_dial       (selected_dial),
    .selected_radio_part (selected_radio_part),
    .double_click        (double_click)
  );

endmodule

`default_nettype wire

### rtl/rdc_checker.sv
// ----------------------------------------------------------------------------
// rdc_checker
// Port-level checks for the rotary dial controller, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rdc_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       send_event,
  input wire logic [2:0] event_kind,
  input wire logic [7:0] repeat_count,
  input wire logic       reconnect_request,
  input wire logic       double_click
);

  // one request in work: accept closes the input until its result moves into the output register
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while previous one still in work");

  a_idle_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !send_event) |-> (event_kind == 3'd0 && repeat_count == 8'd0))
    else $error("no-send result carries kind or count");

  a_toggle_once: assert property (@(posedge clk) disable iff (rst)
    (out_valid && send_event && event_kind == 3'd0) |-> (repeat_count == 8'd1))
    else $error("toggle repeat count not one");

  a_reconnect_alone: assert property (@(posedge clk) disable iff (rst)
    (out_valid && reconnect_request) |-> (!send_event && !double_click))
    else $error("reconnect request combined with event");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(send_event) && $stable(event_kind) && $stable(repeat_count)))
    else $error("stalled result changed");

endmodule

bind rotary_dial_controller_top rdc_checker u_rdc_checker (
  .clk               (clk),
  .rst               (rst),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .send_event        (send_event),
  .event_kind        (event_kind),
  .repeat_count      (repeat_count),
  .reconnect_request (reconnect_request),
  .double_click      (double_click)
);

`default_nettype wire

### dv/rotary_dial_controller_checker.sv
// ----------------------------------------------------------------------------
// rotary_dial_controller_checker
// Watches the request, result and register channels of the dial controller.
// It keeps its own copy of the register values and the dial state, predicts
// the outcome of every accepted request, and compares each accepted result
// field by field against the oldest prediction still owed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rotary_dial_controller_checker
  import rdc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic                in_stall,
  input  wire logic [1:0]          action,
  input  wire logic [31:0]         now_ms,
  input  wire logic                link_up,
  input  wire logic                out_valid,
  input  wire logic                out_stall,
  input  wire logic                send_event,
  input  wire logic [2:0]          event_kind,
  input  wire logic [7:0]          repeat_count,
  input  wire logic                reconnect_request,
  input  wire logic                selected_dial,
  input  wire logic                selected_radio_part,
  input  wire logic                double_click,
  input  wire logic                cfg_valid,
  input  wire logic                cfg_ready,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data,
  output int unsigned              fail_count,
  output int unsigned              results_owed
);

  localparam logic [31:0] FastMs = 32'd15;
  localparam logic [31:0] SlowMs = 32'd120;
  localparam logic [63:0] SpanMs = 64'd105;

  typedef struct packed {
    logic        send;
    event_kind_t kind;
    logic [7:0]  rep;
    logic        reconnect;
    logic        dial;
    logic        part;
    logic        dbl;
  } dial_outcome_t;

  // register copies
  logic [7:0]  accel_mult;
  logic        dual_on;
  logic        radio_on;
  logic [4:0]  bound;
  logic [15:0] dc_window;

  // dial state copies
  logic        dial_sel;
  logic        radio_sel;
  logic        click_armed;
  logic [31:0] click_ms;
  logic        spun;
  logic [31:0] spin_ms;

  dial_outcome_t owed_outcomes[$];

  initial fail_count = 0;
  initial results_owed = 0;

  task automatic flag_error(input string what);
    fail_count++;
    $display("[%0t] MISMATCH: %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) flag_error($sformatf("%s got %0d, want %0d", name, got, want));
  endtask

  // outcome of one dial event; updates the state copies as the block would
  function automatic dial_outcome_t predict_outcome(input action_t act,
                                                    input logic [31:0] stamp,
                                                    input logic link);
    dial_outcome_t r;
    logic          second;
    event_kind_t   kind;
    logic [31:0]   gap;
    logic [63:0]   speed;
    logic [63:0]   cube;
    r = '0;
    case (act)
      ACT_PRESS: begin
        if (!link) begin
          r.reconnect = 1'b1;
        end else if (!radio_on && bound[EV_TOGGLE]) begin
          r.send = 1'b1;
          r.kind = EV_TOGGLE;
          r.rep  = 8'd1;
        end
      end
      ACT_RELEASE: begin
        if (radio_on) begin
          if (click_armed && (stamp - click_ms) <= {16'd0, dc_window}) begin
            click_armed = 1'b0;
            r.dbl = 1'b1;
            if (bound[EV_TOGGLE]) begin
              r.send = 1'b1;
              r.kind = EV_TOGGLE;
              r.rep  = 8'd1;
            end
          end else begin
            radio_sel   = ~radio_sel;
            click_armed = 1'b1;
            click_ms    = stamp;
          end
        end else if (dual_on) begin
          dial_sel = ~dial_sel;
        end
      end
      default: begin
        second = (dual_on && dial_sel) || (radio_on && radio_sel);
        if (act == ACT_CW) kind = second ? EV_INC2 : EV_INC;
        else kind = second ? EV_DEC2 : EV_DEC;
        if (bound[kind]) begin
          r.send = 1'b1;
          r.kind = kind;
          if (accel_mult == 8'd0) begin
            r.rep = 8'd1;
          end else if (!spun) begin
            spun    = 1'b1;
            spin_ms = stamp;
            r.rep   = 8'd1;
          end else begin
            gap     = stamp - spin_ms;
            spin_ms = stamp;
            if (gap <= FastMs) speed = 64'd65536;
            else if (gap >= SlowMs) speed = 64'd0;
            else speed = (64'(SlowMs - gap) << 16) / SpanMs;
            cube  = speed * speed * speed;
            // 1 + (m-1) * t^3 in Q1.48, rounded half up
            r.rep = 8'(64'd1 + (((64'(accel_mult) - 64'd1) * cube + (64'd1 << 47)) >> 48));
          end
        end
      end
    endcase
    r.dial = dial_sel;
    r.part = radio_sel;
    return r;
  endfunction

  always @(posedge clk) begin
    dial_outcome_t want;
    if (rst) begin
      accel_mult  = AccelMultReset;
      dual_on     = 1'b0;
      radio_on    = 1'b0;
      bound       = '0;
      dc_window   = DcWindowReset;
      dial_sel    = 1'b0;
      radio_sel   = 1'b0;
      click_armed = 1'b0;
      click_ms    = '0;
      spun        = 1'b0;
      spin_ms     = '0;
      owed_outcomes.delete();
    end else begin
      // results first: a result leaving at the same edge belongs to an older request
      if (out_valid && !out_stall) begin
        if (owed_outcomes.size() == 0) begin
          flag_error("result with no request outstanding");
        end else begin
          want = owed_outcomes.pop_front();
          check_field("send_event", send_event, want.send);
          check_field("event_kind", event_kind, want.kind);
          check_field("repeat_count", repeat_count, want.rep);
          check_field("reconnect_request", reconnect_request, want.reconnect);
          check_field("selected_dial", selected_dial, want.dial);
          check_field("selected_radio_part", selected_radio_part, want.part);
          check_field("double_click", double_click, want.dbl);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          REG_ACCEL_MULT: accel_mult = cfg_data[7:0];
          REG_DUAL_MODE:  dual_on    = cfg_data[0];
          REG_RADIO_MODE: radio_on   = cfg_data[0];
          REG_BOUND_MASK: bound      = cfg_data[4:0];
          REG_DC_WINDOW:  dc_window  = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        owed_outcomes.push_back(predict_outcome(action_t'(action), now_ms, link_up));
    end
    results_owed <= owed_outcomes.size();
  end

endmodule

### dv/rotary_dial_controller_top_test.sv
// ----------------------------------------------------------------------------
// rotary_dial_controller_top_test
// Stimulus and verdict for the rotary dial controller. A short directed run
// hits the modes, the acceleration breakpoints and timestamp wrap; then
// random phases, each under its own register setting, mix rotation bursts,
// release pairs and single events. Checking lives in the checker module.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rotary_dial_controller_top_test;
  import rdc_pkg::*;

  localparam int unsigned ResetCycles   = 9;
  localparam int unsigned SettleCycles  = 8;     // longest request latency plus margin
  localparam int unsigned QuietLimit    = 2000;  // cycles with no handshake at all
  localparam int unsigned RandomPhases  = 12;
  localparam int unsigned ItemsPerPhase = 90;
  // index with no register behind it; writes there must change nothing
  localparam logic [CfgIdxW-1:0] RegSpare = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // request channel
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  action   = '0;
  logic [31:0] now_ms   = '0;
  logic        link_up  = 1'b0;

  // result channel
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        send_event;
  logic [2:0]  event_kind;
  logic [7:0]  repeat_count;
  logic        reconnect_request;
  logic        selected_dial;
  logic        selected_radio_part;
  logic        double_click;

  // register channel
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data  = '0;

  int unsigned fail_count;
  int unsigned results_owed;
  int unsigned quiet_cycles = 0;

  // stimulus bookkeeping
  logic [31:0] dial_ms   = '0;     // running timestamp for random events
  logic [15:0] window_ms = 16'd400;
  logic        steady    = 1'b0;   // back-to-back requests, no sender gaps

  always #4 clk = ~clk;

  rotary_dial_controller_top dut (.*);

  rotary_dial_controller_checker u_dial_check (.*);

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Time between dial events: fast, mid-curve and slow spins, releases near the
  // double click window edge or inside it, and full-range jumps that wrap the 32-bit clock.
  function automatic logic [31:0] next_delta();
    case ($urandom_range(9))
      0, 1, 2: return 32'($urandom_range(15));
      3, 4:    return 32'($urandom_range(16, 119));
      5:       return 32'($urandom_range(120, 600));
      6, 7:    return 32'(window_ms) + 32'($urandom_range(4)) - 32'd2;
      8:       return 32'($urandom_range(0, window_ms));
      default: return $urandom;
    endcase
  endfunction

  // One dial event. Valid stays high after acceptance unless a gap follows,
  // so back-to-back requests keep valid high between them.
  task automatic issue(input action_t act, input logic [31:0] stamp, input logic link);
    int unsigned rest;
    in_valid <= 1'b1;
    action   <= act;
    now_ms   <= stamp;
    link_up  <= link;
    do @(posedge clk); while (in_stall);
    rest = steady ? 0 : pick_gap();
    if (rest != 0) begin
      in_valid <= 1'b0;
      repeat (rest) @(posedge clk);
    end
  endtask

  // Wait until every predicted result has come back, then let the pipe settle.
  // The first edge lets the owed count catch up with the last acceptance.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Full register setting; unused upper data bits carry noise.
  task automatic configure(input logic [7:0] mult, input logic dual, input logic radio,
                           input logic [4:0] mask, input logic [15:0] window);
    write_reg(REG_ACCEL_MULT, {8'($urandom), mult});
    write_reg(REG_DUAL_MODE,  {15'($urandom), dual});
    write_reg(REG_RADIO_MODE, {15'($urandom), radio});
    write_reg(REG_BOUND_MASK, {11'($urandom), mask});
    write_reg(REG_DC_WINDOW,  window);
    write_reg(RegSpare,       16'($urandom));
    cfg_valid <= 1'b0;
    window_ms = window;
  endtask

  // Result side back-pressure: stall bursts of random length, with long
  // stretches of none at all now and then.
  initial begin
    int unsigned run;
    int unsigned hold;
    forever begin
      run  = ($urandom_range(9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 6);
      hold = pick_gap();
      repeat (run) @(posedge clk);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: any handshake on any channel restarts the count.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned sent;
    int unsigned burst;
    action_t     spin_dir;
    logic [7:0]  mult;
    logic [15:0] window;

    repeat (ResetCycles) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed -----------------------------------------------------------
    // Reset registers: nothing bound, so only the reconnect flag shows up.
    issue(ACT_PRESS, 32'd10, 1'b0);
    issue(ACT_PRESS, 32'd11, 1'b1);
    issue(ACT_CW, 32'd12, 1'b1);     // unbound step leaves the speed timer alone
    drain();

    // Full acceleration, everything bound: walk the speed curve breakpoints.
    configure(8'd255, 1'b0, 1'b0, 5'h1F, 16'd400);
    issue(ACT_PRESS, 32'd20, 1'b1);          // plain toggle
    issue(ACT_CW, 32'd1000, 1'b0);           // first step after reset
    issue(ACT_CW, 32'd1005, 1'b1);           // well inside the fast zone
    issue(ACT_CCW, 32'd1020, 1'b1);          // fast edge
    issue(ACT_CW, 32'd1036, 1'b1);           // just past the fast edge
    issue(ACT_CCW, 32'd1155, 1'b1);          // just short of the slow edge
    issue(ACT_CW, 32'd1275, 1'b1);           // slow edge
    issue(ACT_CW, 32'd1275, 1'b1);           // same millisecond
    issue(ACT_CCW, 32'hFFFF_FFF8, 1'b1);     // huge gap
    issue(ACT_CW, 32'h0000_0002, 1'b1);      // fast step across the clock wrap
    issue(ACT_RELEASE, 32'd3, 1'b1);         // release with both modes off
    drain();

    // Radio and dual at once, zero window: only a same-millisecond release pairs.
    configure(8'd7, 1'b1, 1'b1, 5'h1F, 16'd0);
    issue(ACT_PRESS, 32'd100, 1'b1);         // radio mode swallows the press
    issue(ACT_RELEASE, 32'd100, 1'b0);       // flip to standby, click armed
    issue(ACT_RELEASE, 32'd100, 1'b1);       // double click
    issue(ACT_RELEASE, 32'd101, 1'b1);       // flip back, armed again
    issue(ACT_RELEASE, 32'd102, 1'b1);       // one ms late: flips again
    issue(ACT_CW, 32'd150, 1'b1);            // standby part routes to inc2
    issue(ACT_CCW, 32'hFFFF_FFFF, 1'b1);     // dec2
    drain();

    // No acceleration, dual only, toggle unbound, widest window.
    configure(8'd0, 1'b1, 1'b0, 5'h1A, 16'hFFFF);
    issue(ACT_RELEASE, 32'd5, 1'b1);         // sub-dial flip
    issue(ACT_CW, 32'd6, 1'b1);
    issue(ACT_CCW, 32'd7, 1'b0);
    issue(ACT_PRESS, 32'd8, 1'b0);
    issue(ACT_PRESS, 32'd9, 1'b1);           // toggle not bound
    drain();

    // --- random phases ------------------------------------------------------
    for (int phase = 0; phase < RandomPhases; phase++) begin
      case ($urandom_range(4))
        0:       mult = 8'd0;
        1:       mult = 8'd1;
        2:       mult = 8'd255;
        3:       mult = 8'd3;
        default: mult = 8'($urandom_range(255));
      endcase
      if (phase == 0) mult = 8'd1;   // unit multiplier gets at least one phase
      case ($urandom_range(3))
        0:       window = 16'd0;
        1:       window = 16'hFFFF;
        2:       window = 16'd400;
        default: window = 16'($urandom_range(300));
      endcase
      configure(mult, 1'($urandom_range(1)), 1'($urandom_range(1)),
                ($urandom_range(3) == 0) ? 5'($urandom_range(31)) : 5'h1F, window);
      steady = ($urandom_range(3) == 0);
      // every fourth phase starts just below the wrap of the ms clock
      if (phase % 4 == 3) dial_ms = 32'hFFFF_FF00 + 32'($urandom_range(255));

      sent = 0;
      while (sent < ItemsPerPhase) begin
        case ($urandom_range(9))
          0, 1, 2: begin
            // spin burst in one direction, fast and mid-curve steps
            burst    = $urandom_range(3, 8);
            spin_dir = $urandom_range(1) ? ACT_CW : ACT_CCW;
            repeat (burst) begin
              dial_ms = dial_ms + 32'($urandom_range(40));
              issue(spin_dir, dial_ms, 1'($urandom_range(1)));
            end
            sent += burst;
          end
          3, 4: begin
            // release pair: double click candidate
            repeat (2) begin
              dial_ms = dial_ms + next_delta();
              issue(ACT_RELEASE, dial_ms, 1'($urandom_range(1)));
            end
            sent += 2;
          end
          default: begin
            dial_ms = dial_ms + next_delta();
            issue(action_t'($urandom_range(3)), dial_ms, $urandom_range(6) != 0);
            sent++;
          end
        endcase
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### rotary_dial_controller_top.f
rtl/rdc_pkg.sv
rtl/rdc_ctrl.sv
rtl/rdc_datapath.sv
rtl/rotary_dial_controller_top.sv
rtl/rdc_checker.sv
dv/rotary_dial_controller_checker.sv
dv/rotary_dial_controller_top_test.sv
